FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 8;

  localparam int PRIO_W   = 32;
  localparam int TAG_W    = 8;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;

  // Request opcodes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                push;
    logic                pop;
    logic                load;
    logic [STATUS_W-1:0] status;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } spq_flags_t;

endpackage

FILE: rtl/core/spq_req_if.sv
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]         tag;

  modport source (output valid, cmd, priority_req, tag, input ready);
  modport sink   (input valid, cmd, priority_req, tag, output ready);
endinterface

FILE: rtl/core/spq_rsp_if.sv
`timescale 1ns / 1ps

interface spq_rsp_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TAG_W-1:0]         head_tag;
  logic signed [PRIO_W-1:0] head_priority;
  logic [OCC_W-1:0]         occupancy;
  logic                     empty_flag;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, head_tag, head_priority, occupancy, empty_flag, status,
                  input ready);
  modport sink   (input valid, head_tag, head_priority, occupancy, empty_flag, status,
                  output ready);
endinterface

FILE: rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_cmd,
  output logic       req_ready,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  input  spq_flags_t flags,
  output spq_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // A new transaction may enter whenever the result register is free or is
  // being emptied in this same cycle.
  assign req_ready = (state == ST_IDLE) || rsp_ready;
  assign rsp_valid = (state == ST_HOLD);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.load   = accept;
    cmd.push   = accept && (req_cmd == CMD_PUSH) && !flags.full;
    cmd.pop    = accept && (req_cmd == CMD_POP) && !flags.empty;
    cmd.status = STATUS_OK;
    if (req_cmd == CMD_PUSH && flags.full) begin
      cmd.status = STATUS_FULL;
    end else if (req_cmd == CMD_POP && flags.empty) begin
      cmd.status = STATUS_POP_EMPTY;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/spq_dp.sv
`timescale 1ns / 1ps

module spq_dp import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spq_cmd_t                 cmd,
  input  logic signed [PRIO_W-1:0] prio_in,
  input  logic [TAG_W-1:0]         tag_in,
  output spq_flags_t               flags,
  output logic [TAG_W-1:0]         res_head_tag,
  output logic signed [PRIO_W-1:0] res_head_priority,
  output logic [OCC_W-1:0]         res_occupancy,
  output logic                     res_empty,
  output logic [STATUS_W-1:0]      res_status
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int KEEP  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  logic signed [PRIO_W-1:0] prio_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_q  [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [TAG_BITS-1:0]      tag_new;
  logic                     in_front;
  logic [QUEUE_DEPTH-1:0]   stay;
  logic signed [PRIO_W-1:0] head_prio_next;
  logic [TAG_BITS-1:0]      head_tag_next;

  assign tag_new     = TAG_BITS'(tag_in[KEEP-1:0]);
  assign flags.empty = (count == '0);
  assign flags.full  = (count == CNT_W'(QUEUE_DEPTH));

  // The new entry takes the front when the queue is empty or it beats the
  // head; otherwise it lands after the run of valid entries below it.
  assign in_front = flags.empty || (prio_in < prio_q[0]);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign stay[g] = !in_front;
        always_ff @(posedge clk) begin
          if (cmd.push) begin
            if (!stay[g]) begin
              prio_q[g] <= prio_in;
              tag_q[g]  <= tag_new;
            end
          end else if (cmd.pop) begin
            prio_q[g] <= prio_q[g+1];
            tag_q[g]  <= tag_q[g+1];
          end
        end
      end else begin : g_body
        assign stay[g] = !in_front && (count > CNT_W'(g)) && (prio_q[g] < prio_in);
        always_ff @(posedge clk) begin
          if (cmd.push) begin
            if (!stay[g]) begin
              if (stay[g-1]) begin
                prio_q[g] <= prio_in;
                tag_q[g]  <= tag_new;
              end else begin
                prio_q[g] <= prio_q[g-1];
                tag_q[g]  <= tag_q[g-1];
              end
            end
          end else if (cmd.pop) begin
            if (g < QUEUE_DEPTH - 1) begin
              prio_q[g] <= prio_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
              tag_q[g]  <= tag_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next     = count;
    head_prio_next = prio_q[0];
    head_tag_next  = tag_q[0];
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
      if (in_front) begin
        head_prio_next = prio_in;
        head_tag_next  = tag_new;
      end
    end else if (cmd.pop) begin
      count_next     = count - CNT_W'(1);
      head_prio_next = prio_q[1];
      head_tag_next  = tag_q[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register; payload only, qualified by the controller's valid.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_occupancy <= OCC_W'(count_next);
      res_empty     <= (count_next == '0);
      res_status    <= cmd.status;
      if (count_next == '0) begin
        res_head_priority <= '0;
        res_head_tag      <= '0;
      end else begin
        res_head_priority <= head_prio_next;
        res_head_tag      <= TAG_W'(head_tag_next[KEEP-1:0]);
      end
    end
  end

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Sorted priority queue, ascending: the entry with the smallest signed
// Q16.16 priority is always at the head.
// Request channel (req): cmd selects push or pop; a push carries
// priority_req and tag. A push below the head goes to the front, otherwise
// it goes after the head, ahead of later entries of equal or greater value.
// Response channel (rsp): exactly one transaction per request, showing the
// head tag and priority (zero when empty), occupancy, empty flag and status
// (ok, push refused because full, or pop on empty).
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle unless a held response stalls; all cells
// compare and shift in parallel, so the accepting edge completes an insert or pop.
// Stalls: the result register holds its transaction while rsp.ready is low,
// and req.ready stays low until it drains or is drained in the same cycle.
// Reset: the queue becomes empty and no response is pending; the entry
// storage itself is not cleared, since only held entries are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  spq_cmd_t   cmd;
  spq_flags_t flags;

  // Controller: tracks whether the result register is occupied and turns
  // each accepted request into a datapath command plus its status code.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Datapath: the row of compare-and-shift cells, the entry count and the
  // result register.
  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .prio_in           (req.priority_req),
    .tag_in            (req.tag),
    .flags             (flags),
    .res_head_tag      (rsp.head_tag),
    .res_head_priority (rsp.head_priority),
    .res_occupancy     (rsp.occupancy),
    .res_empty         (rsp.empty_flag),
    .res_status        (rsp.status)
  );

  // The count can never read as both empty and full.
  `SPQ_ASSERT_SAME(a_flags_exclusive, clk, rst, 1'b1, !(flags.empty && flags.full))

  // A pop taken on an empty queue is answered next cycle with the pop-empty code.
  `SPQ_ASSERT_NEXT(a_pop_empty_status, clk, rst,
    req.valid && req.ready && req.cmd == CMD_POP && flags.empty,
    rsp.valid && rsp.status == STATUS_POP_EMPTY && rsp.empty_flag)

  // A push taken with room left always leaves a non-empty queue.
  `SPQ_ASSERT_NEXT(a_push_fills, clk, rst,
    req.valid && req.ready && req.cmd == CMD_PUSH && !flags.full,
    rsp.valid && !rsp.empty_flag && rsp.status == STATUS_OK)

  // A push refused because the queue is full leaves it full.
  `SPQ_ASSERT_NEXT(a_full_refused, clk, rst,
    req.valid && req.ready && req.cmd == CMD_PUSH && flags.full,
    flags.full && rsp.status == STATUS_FULL)

endmodule

FILE: bench/queue_order_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own sorted copy of the queue and checks
// every response transaction against the head view it predicts.
module queue_order_checker import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_rsp_if   rsp,
  output int   failures,
  output int   pending,
  output int   full_seen,
  output int   empty_seen
);

  localparam int REPORT_LIMIT = 10;
  localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 1);

  typedef struct packed {
    logic [TAG_W-1:0]         head_tag;
    logic signed [PRIO_W-1:0] head_priority;
    logic [OCC_W-1:0]         occupancy;
    logic                     empty_flag;
    logic [STATUS_W-1:0]      status;
  } head_view_t;

  // Shadow queue, kept in ascending priority order.
  logic signed [PRIO_W-1:0] prio_store [QUEUE_DEPTH];
  logic [TAG_W-1:0]         tag_store  [QUEUE_DEPTH];
  int                       held;

  head_view_t predicted_heads [$];
  int                       rsp_index;

  // Applies one push or pop to the shadow queue and returns the head view.
  function automatic head_view_t apply_queue_op(logic op, logic signed [PRIO_W-1:0] p,
                                                logic [TAG_W-1:0] t);
    head_view_t view;
    int slot;
    int i;
    view.status = STATUS_OK;
    if (op == CMD_PUSH) begin
      if (held >= QUEUE_DEPTH) begin
        view.status = STATUS_FULL;
      end else begin
        // Below the head goes to the front; otherwise it lands after the
        // head, in front of the first later entry that is not smaller.
        slot = 0;
        if (held != 0 && !(p < prio_store[0])) begin
          slot = 1;
          while (slot < held && prio_store[slot] < p) slot++;
        end
        for (i = held; i > slot; i--) begin
          prio_store[i] = prio_store[i-1];
          tag_store[i]  = tag_store[i-1];
        end
        prio_store[slot] = p;
        tag_store[slot]  = t & TAG_MASK;
        held++;
      end
    end else if (held == 0) begin
      view.status = STATUS_POP_EMPTY;
    end else begin
      for (i = 1; i < held; i++) begin
        prio_store[i-1] = prio_store[i];
        tag_store[i-1]  = tag_store[i];
      end
      held--;
    end
    view.occupancy     = OCC_W'(held);
    view.empty_flag    = (held == 0);
    view.head_tag      = (held == 0) ? '0 : tag_store[0];
    view.head_priority = (held == 0) ? '0 : prio_store[0];
    return view;
  endfunction

  always @(posedge clk) begin
    head_view_t want;
    head_view_t got;
    if (rst) begin
      held = 0;
      rsp_index = 0;
      failures = 0;
      full_seen = 0;
      empty_seen = 0;
      predicted_heads.delete();
      pending <= 0;
    end else begin
      // The response taken at this edge always belongs to an older request,
      // so it is checked before the request of this edge is predicted.
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.head_tag, rsp.head_priority, rsp.occupancy, rsp.empty_flag, rsp.status};
        if (predicted_heads.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("response %0d arrived with no request outstanding: tag %0h prio %0d",
                     rsp_index, got.head_tag, got.head_priority);
        end else begin
          want = predicted_heads.pop_front();
          if (want.head_tag !== got.head_tag || want.head_priority !== got.head_priority ||
              want.occupancy !== got.occupancy || want.empty_flag !== got.empty_flag ||
              want.status !== got.status) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("response %0d expected tag %0h prio %0d occ %0d empty %0b status %0d",
                       rsp_index, want.head_tag, want.head_priority, want.occupancy,
                       want.empty_flag, want.status);
              $display("response %0d actual   tag %0h prio %0d occ %0d empty %0b status %0d",
                       rsp_index, got.head_tag, got.head_priority, got.occupancy,
                       got.empty_flag, got.status);
            end
          end
        end
        rsp_index++;
      end
      if (req.valid && req.ready) begin
        want = apply_queue_op(req.cmd, req.priority_req, req.tag);
        if (want.status == STATUS_FULL) full_seen++;
        if (want.status == STATUS_POP_EMPTY) empty_seen++;
        predicted_heads.push_back(want);
      end
      pending <= predicted_heads.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Top of the bench for the sorted priority queue. It only makes stimulus and
// gives the verdict; the order checker instantiated beside the block watches
// both channels, predicts every response and counts mismatches.
module testbench;
  import spq_pkg::*;

  // SETTLE_CYCLES quiet cycles in a row are normal at the end; IDLE_LIMIT of them
  // means the block has stopped taking or giving transactions.
  localparam int IDLE_LIMIT     = 1000;
  localparam int PHASE_ITEMS    = 250;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RESET_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  int failures;
  int pending;
  int full_seen;
  int empty_seen;

  // Percentages that shape the current phase, then burst and progress counts.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int push_bias      = 50;
  int burst_left     = 0;
  int pushes_sent    = 0;
  int pops_sent      = 0;
  int quiet_cycles   = 0;

  sorted_priority_queue uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_order_checker order_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .failures   (failures),
    .pending    (pending),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  // The receiver stalls at random with the probability of the current phase.
  // Ready changes only at rising edges, so the checker and the block both see
  // the value that was set up before the edge.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request transaction and returns at the edge where it is taken.
  // Idle cycles in front of it are drawn one at a time, so gaps land before
  // any request and in every state of the queue. When no gap is drawn, valid
  // simply stays high and the new payload replaces the old one.
  task automatic send_item(input logic op, input logic signed [PRIO_W-1:0] p,
                           input logic [TAG_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= op;
    req_ch.priority_req <= p;
    req_ch.tag          <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == CMD_PUSH) pushes_sent++;
    else pops_sent++;
  endtask

  // Holds the sender back until every outstanding response has been taken.
  // A clock edge passes before pending is polled, so the last request is counted.
  task automatic drain_queue_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Priorities mix the extremes, a handful of close values that produce
  // ties with the head and with later entries, and fully random patterns
  // that toggle every bit.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      1:       return PRIO_W'(($urandom_range(8) - 4) * 32'sh0001_0000);
      default: return $urandom;
    endcase
  endfunction

  // Random traffic comes in bursts that lean towards pushes, towards pops or
  // neither, so the queue keeps swinging between empty and full and both
  // refusal cases are exercised many times, not just the middle of the range.
  task automatic send_random_item();
    logic op;
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 40);
      case ($urandom_range(2))
        0:       push_bias = 85;
        1:       push_bias = 15;
        default: push_bias = 50;
      endcase
    end
    burst_left--;
    op = ($urandom_range(99) < push_bias) ? CMD_PUSH : CMD_POP;
    send_item(op, pick_priority(), TAG_W'($urandom));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      send_random_item();
      // Now and then the sender waits for the queue to go quiet mid-phase.
      if ($urandom_range(199) == 0) drain_queue_responses();
    end
    drain_queue_responses();
  endtask

  // Any accepted transaction on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, giving up", IDLE_LIMIT);
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_PUSH;
    req_ch.priority_req <= '0;
    req_ch.tag          <= '0;
    rst                 <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with no idling: a pop on the empty queue, a push onto
    // the empty queue, a push below the head, a push equal to the head, the
    // largest and smallest priorities, a push tied with a later entry and the
    // tag extremes. The pops then empty the queue and go one step past empty.
    send_item(CMD_POP,  32'sh0000_0000, 8'h00);
    send_item(CMD_PUSH, 32'sh0001_0000, 8'h01);
    send_item(CMD_PUSH, 32'sh8000_0000, 8'h00);
    send_item(CMD_PUSH, 32'sh8000_0000, 8'hff);
    send_item(CMD_PUSH, 32'sh7fff_ffff, 8'haa);
    send_item(CMD_PUSH, 32'sh0001_0000, 8'h55);
    send_item(CMD_PUSH, 32'shffff_ffff, 8'h80);
    send_item(CMD_PUSH, 32'sh0000_0000, 8'h7f);
    send_item(CMD_PUSH, 32'sh7fff_ffff, 8'h33);
    repeat (9) send_item(CMD_POP, 32'shffff_ffff, 8'hff);
    drain_queue_responses();

    // Random phases: no idling, a slow sender, a slow receiver, then both.
    run_phase(0, 0);
    run_phase(57, 0);
    run_phase(0, 57);
    run_phase(15, 15);

    // Let any stray response show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d pushes and %0d pops through four idle and stall phases,",
             pushes_sent, pops_sent);
    $display("including %0d pushes refused on a full queue and %0d pops on an empty one.",
             full_seen, empty_seen);
    if (failures == 0 && pending == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("%0d mismatches, %0d responses still outstanding", failures, pending);
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_dp.sv
rtl/core/sorted_priority_queue.sv
bench/queue_order_checker.sv
bench/testbench.sv
